// File: rtl/core/ll1sp_pkg.sv
// Package with types, grammar tables and lookup helpers of the LL(1) S-expression parser.
`timescale 1ns / 1ps
`default_nettype none

package ll1sp_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 64;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);

   // Per-token limits.
   localparam int MAX_ITEMS  = 8;
   localparam int MAX_EXPAND = 16;

   // Grammar symbols. Terminals share their codes with the token kinds.
   localparam logic [4:0] SYM_NUM    = 5'd0;
   localparam logic [4:0] SYM_SIMPLE = 5'd1;
   localparam logic [4:0] SYM_ABBREV = 5'd2;
   localparam logic [4:0] SYM_DCOM   = 5'd3;
   localparam logic [4:0] SYM_VOPEN  = 5'd4;
   localparam logic [4:0] SYM_BOPEN  = 5'd5;
   localparam logic [4:0] SYM_LPAR   = 5'd6;
   localparam logic [4:0] SYM_RPAR   = 5'd7;
   localparam logic [4:0] SYM_DOT    = 5'd8;
   localparam logic [4:0] SYM_LBRK   = 5'd9;
   localparam logic [4:0] SYM_RBRK   = 5'd10;
   localparam logic [4:0] SYM_END    = 5'd11;
   localparam logic [4:0] NT_BYTES   = 5'd13;
   localparam logic [4:0] NT_DATUM   = 5'd14;
   localparam logic [4:0] NT_ELEMS   = 5'd15;
   localparam logic [4:0] NT_INTER   = 5'd16;
   localparam logic [4:0] NT_TAIL    = 5'd17;
   localparam logic [4:0] NT_PROG    = 5'd18;
   localparam logic [4:0] NT_COMM    = 5'd19;
   localparam logic [4:0] NT_COMMS   = 5'd20;

   localparam logic [4:0] NT_BASE   = NT_BYTES;
   localparam int         NT_COUNT  = 8;
   localparam int         TOK_COUNT = 12;
   localparam int         NUM_PRODS = 26;

   // Build actions.
   localparam logic [2:0] ACT_BEGIN_LIST = 3'd0;
   localparam logic [2:0] ACT_BEGIN_VEC  = 3'd1;
   localparam logic [2:0] ACT_BEGIN_BVEC = 3'd2;
   localparam logic [2:0] ACT_END_SEQ    = 3'd3;
   localparam logic [2:0] ACT_DOT_END    = 3'd4;
   localparam logic [2:0] ACT_ABBREV     = 3'd5;
   localparam logic [2:0] ACT_DISCARD    = 3'd6;
   localparam logic [2:0] ACT_NONE       = 3'd7;

   localparam logic [4:0] RULE_NONE = 5'd31;

   typedef enum logic [2:0] {
      KIND_ACTION   = 3'd0,
      KIND_VALUE    = 3'd1,
      KIND_ACCEPT   = 3'd2,
      KIND_DATUM    = 3'd3,
      KIND_EOI      = 3'd4,
      KIND_SYNTAX   = 3'd5,
      KIND_OVERFLOW = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FETCH,
      ST_EVAL,
      ST_PUSH,
      ST_ACT,
      ST_VAL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic        has_value;
      logic [31:0] token_value;
   } req_type;

   typedef struct packed {
      kind_type    item_kind;
      logic [2:0]  action_code;
      logic [31:0] value_out;
      logic        last;
   } rsp_type;

   // Stack port controls driven by the sequencer.
   typedef struct packed {
      logic                we;
      logic [STACK_AW-1:0] waddr;
      logic [4:0]          wdata;
      logic [STACK_AW-1:0] raddr;
   } stk_req_type;

   typedef struct packed {
      logic [2:0]      len;
      logic [2:0]      act;
      logic [0:3][4:0] rhs;
   } prod_type;

   localparam prod_type PRODS [NUM_PRODS] = '{
      '{3'd2, ACT_NONE,       '{NT_COMM,   NT_PROG,  SYM_NUM,  SYM_NUM}},
      '{3'd1, ACT_NONE,       '{NT_DATUM,  SYM_NUM,  SYM_NUM,  SYM_NUM}},
      '{3'd0, ACT_NONE,       '{SYM_NUM,   SYM_NUM,  SYM_NUM,  SYM_NUM}},
      '{3'd1, ACT_NONE,       '{SYM_NUM,   SYM_NUM,  SYM_NUM,  SYM_NUM}},
      '{3'd1, ACT_NONE,       '{SYM_SIMPLE, SYM_NUM, SYM_NUM,  SYM_NUM}},
      '{3'd3, ACT_BEGIN_LIST, '{SYM_LPAR,  NT_INTER, SYM_RPAR, SYM_NUM}},
      '{3'd3, ACT_BEGIN_LIST, '{SYM_LBRK,  NT_INTER, SYM_RBRK, SYM_NUM}},
      '{3'd3, ACT_BEGIN_VEC,  '{SYM_VOPEN, NT_ELEMS, SYM_RPAR, SYM_NUM}},
      '{3'd3, ACT_BEGIN_BVEC, '{SYM_BOPEN, NT_BYTES, SYM_RPAR, SYM_NUM}},
      '{3'd2, ACT_ABBREV,     '{SYM_ABBREV, NT_DATUM, SYM_NUM, SYM_NUM}},
      '{3'd2, ACT_NONE,       '{NT_DATUM,  NT_TAIL,  SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_NONE,       '{NT_COMM,   NT_INTER, SYM_NUM,  SYM_NUM}},
      '{3'd0, ACT_END_SEQ,    '{SYM_NUM,   SYM_NUM,  SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_NONE,       '{NT_DATUM,  NT_TAIL,  SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_NONE,       '{NT_COMM,   NT_TAIL,  SYM_NUM,  SYM_NUM}},
      '{3'd4, ACT_DOT_END,    '{SYM_DOT,   NT_COMMS, NT_DATUM, NT_COMMS}},
      '{3'd0, ACT_END_SEQ,    '{SYM_NUM,   SYM_NUM,  SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_NONE,       '{NT_DATUM,  NT_ELEMS, SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_NONE,       '{NT_COMM,   NT_ELEMS, SYM_NUM,  SYM_NUM}},
      '{3'd0, ACT_END_SEQ,    '{SYM_NUM,   SYM_NUM,  SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_NONE,       '{SYM_NUM,   NT_BYTES, SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_NONE,       '{NT_COMM,   NT_BYTES, SYM_NUM,  SYM_NUM}},
      '{3'd0, ACT_END_SEQ,    '{SYM_NUM,   SYM_NUM,  SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_DISCARD,    '{SYM_DCOM,  NT_DATUM, SYM_NUM,  SYM_NUM}},
      '{3'd2, ACT_NONE,       '{NT_COMM,   NT_COMMS, SYM_NUM,  SYM_NUM}},
      '{3'd0, ACT_NONE,       '{SYM_NUM,   SYM_NUM,  SYM_NUM,  SYM_NUM}}
   };

   // Parse table. Rows: bytes, datum, elements, interior, tail, program, comment,
   // comments. Columns follow the token kinds.
   localparam logic [4:0] RULE_TABLE [NT_COUNT][TOK_COUNT] = '{
      '{5'd20, RULE_NONE, RULE_NONE, 5'd21, RULE_NONE, RULE_NONE, RULE_NONE, 5'd22,
        RULE_NONE, RULE_NONE, RULE_NONE, RULE_NONE},
      '{5'd3, 5'd4, 5'd9, RULE_NONE, 5'd7, 5'd8, 5'd5, RULE_NONE,
        RULE_NONE, 5'd6, RULE_NONE, RULE_NONE},
      '{5'd17, 5'd17, 5'd17, 5'd18, 5'd17, 5'd17, 5'd17, 5'd19,
        RULE_NONE, 5'd17, RULE_NONE, RULE_NONE},
      '{5'd10, 5'd10, 5'd10, 5'd11, 5'd10, 5'd10, 5'd10, 5'd12,
        RULE_NONE, 5'd10, 5'd12, RULE_NONE},
      '{5'd13, 5'd13, 5'd13, 5'd14, 5'd13, 5'd13, 5'd13, 5'd16,
        5'd15, 5'd13, 5'd16, RULE_NONE},
      '{5'd1, 5'd1, 5'd1, 5'd0, 5'd1, 5'd1, 5'd1, RULE_NONE,
        RULE_NONE, 5'd1, RULE_NONE, 5'd2},
      '{RULE_NONE, RULE_NONE, RULE_NONE, 5'd23, RULE_NONE, RULE_NONE, RULE_NONE,
        RULE_NONE, RULE_NONE, RULE_NONE, RULE_NONE, RULE_NONE},
      '{5'd25, 5'd25, 5'd25, 5'd24, 5'd25, 5'd25, 5'd25, 5'd25,
        RULE_NONE, 5'd25, 5'd25, RULE_NONE}
   };

   // Production for a nonterminal under a lookahead token, or RULE_NONE.
   function automatic logic [4:0] rule_lookup(input logic [4:0] sym, input logic [3:0] tok);
      logic [4:0] off;
      off = sym - NT_BASE;
      if ((sym >= NT_BASE) && (sym < NT_BASE + 5'(NT_COUNT)) && (tok < 4'(TOK_COUNT))) begin
         return RULE_TABLE[off[2:0]][tok];
      end
      return RULE_NONE;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ll1sp_stack.sv
// Symbol stack memory with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ll1sp_stack (
   input  wire logic                    clock,
   input  wire ll1sp_pkg::stk_req_type  stk_req,
   output logic [4:0]                   rd_data
);
   import ll1sp_pkg::*;

   logic [4:0] mem [STACK_DEPTH];
   logic [4:0] rd_ff;

   always_ff @(posedge clock) begin
      if (stk_req.we) begin
         mem[stk_req.waddr] <= stk_req.wdata;
      end
      rd_ff <= mem[stk_req.raddr];
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

// File: rtl/core/ll1sp_ctrl.sv
// Parse sequencer: table lookup, stack expansion, token match and result register.
`timescale 1ns / 1ps
`default_nettype none

module ll1sp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ll1sp_pkg::req_type      req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output ll1sp_pkg::rsp_type           rsp_data,
   output ll1sp_pkg::stk_req_type       stk_req,
   input  wire logic [4:0]              stk_rd_data
);
   import ll1sp_pkg::*;

   state_type   state_ff, state_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [3:0]  tok_ff, tok_in;
   logic        hasv_ff, hasv_in;
   logic [31:0] val_ff, val_in;
   logic [4:0]  rule_ff, rule_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [2:0]  n_ff, n_in;
   logic [3:0]  iter_ff, iter_in;
   logic        emitted_ff, emitted_in;
   logic        bottom_ff, bottom_in;
   kind_type    fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic            load;
   rsp_type         load_item;
   logic            out_free;
   logic            room;
   logic [SP_W-1:0] sp_m1;
   logic [4:0]      sym_top;
   logic [4:0]      rule_hit;
   logic            rule_ok;
   prod_type        prod_hit;
   prod_type        prod_cur;
   logic [2:0]      cnt_m1;
   logic [SP_W:0]   need;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign room     = (n_ff != 3'(MAX_ITEMS - 1));
   assign sp_m1    = sp_ff - 1'b1;
   // The end marker only ever lives at the bottom entry, so it is not read back.
   assign sym_top  = bottom_ff ? SYM_END : stk_rd_data;
   assign rule_hit = rule_lookup(sym_top, tok_ff);
   assign rule_ok  = (rule_hit != RULE_NONE);
   assign prod_hit = PRODS[rule_ok ? rule_hit : 5'd0];
   assign prod_cur = PRODS[rule_ff];
   assign cnt_m1   = cnt_ff - 3'd1;
   assign need     = {1'b0, sp_m1} + (SP_W + 1)'(prod_hit.len);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sp_ff        <= SP_W'(2);
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_ff      <= tok_in;
      hasv_ff     <= hasv_in;
      val_ff      <= val_in;
      rule_ff     <= rule_in;
      cnt_ff      <= cnt_in;
      n_ff        <= n_in;
      iter_ff     <= iter_in;
      bottom_ff   <= bottom_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      tok_in        = tok_ff;
      hasv_in       = hasv_ff;
      val_in        = val_ff;
      rule_in       = rule_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      iter_in       = iter_ff;
      emitted_in    = emitted_ff;
      bottom_in     = bottom_ff;
      fin_in        = fin_ff;
      load          = 1'b0;
      load_item     = '{KIND_ACTION, 3'd0, 32'd0, 1'b0};
      stk_req.we    = 1'b0;
      stk_req.waddr = sp_ff[STACK_AW-1:0];
      stk_req.wdata = NT_PROG;
      stk_req.raddr = sp_m1[STACK_AW-1:0];
      req_ready     = 1'b0;

      case (state_ff)
         ST_INIT: begin
            stk_req.we    = 1'b1;
            stk_req.waddr = STACK_AW'(1);
            state_in      = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               tok_in   = req_data.token_kind;
               hasv_in  = req_data.has_value;
               val_in   = req_data.token_value;
               n_in     = 3'd0;
               iter_in  = 4'd0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            bottom_in = (sp_ff == SP_W'(1));
            if ((sp_ff == '0) || (sp_ff > SP_W'(STACK_DEPTH))) begin
               fin_in   = KIND_EOI;
               state_in = ST_FIN;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (rule_ok) begin
               if (need > (SP_W + 1)'(STACK_DEPTH)) begin
                  fin_in   = KIND_OVERFLOW;
                  state_in = ST_FIN;
               end else begin
                  sp_in    = sp_m1;
                  rule_in  = rule_hit;
                  cnt_in   = prod_hit.len;
                  state_in = (prod_hit.len != 3'd0) ? ST_PUSH : ST_ACT;
               end
            end else if (sym_top == SYM_END) begin
               fin_in   = KIND_EOI;
               state_in = ST_FIN;
            end else if (sym_top != {1'b0, tok_ff}) begin
               fin_in   = KIND_SYNTAX;
               state_in = ST_FIN;
            end else begin
               sp_in = sp_m1;
               if (hasv_ff && room) begin
                  state_in = ST_VAL;
               end else begin
                  fin_in   = (emitted_ff && (sp_m1 == SP_W'(1))) ? KIND_DATUM : KIND_ACCEPT;
                  state_in = ST_FIN;
               end
            end
         end
         ST_PUSH: begin
            // Right-hand side goes on last symbol first.
            stk_req.we    = 1'b1;
            stk_req.wdata = prod_cur.rhs[cnt_m1[1:0]];
            sp_in         = sp_ff + 1'b1;
            cnt_in        = cnt_m1;
            if (cnt_ff == 3'd1) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            if ((prod_cur.act != ACT_NONE) && room && !out_free) begin
               state_in = ST_ACT;
            end else begin
               if ((prod_cur.act != ACT_NONE) && room) begin
                  load       = 1'b1;
                  load_item  = '{KIND_ACTION, prod_cur.act, 32'd0, 1'b0};
                  n_in       = n_ff + 3'd1;
                  emitted_in = 1'b1;
               end
               if (iter_ff == 4'(MAX_EXPAND - 1)) begin
                  fin_in   = KIND_SYNTAX;
                  state_in = ST_FIN;
               end else begin
                  iter_in  = iter_ff + 4'd1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_VAL: begin
            if (out_free) begin
               load       = 1'b1;
               load_item  = '{KIND_VALUE, 3'd0, val_ff, 1'b0};
               n_in       = n_ff + 3'd1;
               emitted_in = 1'b1;
               fin_in     = (sp_ff == SP_W'(1)) ? KIND_DATUM : KIND_ACCEPT;
               state_in   = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               load      = 1'b1;
               load_item = '{fin_ff, 3'd0, 32'd0, 1'b1};
               state_in  = ST_IDLE;
               if (fin_ff != KIND_ACCEPT) begin
                  // Restart: end marker stays at the bottom, start symbol above it.
                  sp_in         = SP_W'(2);
                  emitted_in    = 1'b0;
                  stk_req.we    = 1'b1;
                  stk_req.waddr = STACK_AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = load ? load_item : rsp_data_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/ll1_sexpr_parse_engine_unit.sv
// Top level of the table-driven LL(1) S-expression parse engine.
//
// The req channel takes one scanner token per item (kind, value flag, value handle).
// The rsp channel returns, for each token, zero or more build-action and value items
// followed by exactly one status item with last set: accepted, datum complete, end of
// input, syntax error or stack overflow. Any status other than accepted restarts the
// parser with the end marker and the start symbol on the stack.
// One token is in work at a time; req_ready is high only while the engine is idle.
// Each stack expansion steps through a read, a lookup, one push per right-hand
// symbol and an action, the final match steps through a read and a compare, and each
// value or status item takes a step of its own. The symbol stack, read one
// entry at a time through a register, sets this pace.
// Results leave through an output register; while the receiver stalls, the engine
// holds in its current step until that register frees up.
// After reset the engine seeds the stack in its ST_INIT state before it raises req_ready.
`timescale 1ns / 1ps
`default_nettype none

module ll1_sexpr_parse_engine_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ll1sp_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output ll1sp_pkg::rsp_type      rsp_data
);
   import ll1sp_pkg::*;

   stk_req_type stk_req;
   logic [4:0]  stk_rd_data;

   ll1sp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .stk_req     (stk_req),
      .stk_rd_data (stk_rd_data)
   );

   ll1sp_stack u_stack (
      .clock   (clock),
      .stk_req (stk_req),
      .rd_data (stk_rd_data)
   );

endmodule

`default_nettype wire

// File: rtl/core/ll1sp_checker.sv
// Port-level checker for the parse engine and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ll1sp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire ll1sp_pkg::rsp_type rsp_data
);
   import ll1sp_pkg::*;

   // The engine seeds its stack after reset, before it raises req_ready.
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // A token holds the engine busy at least until its status item is built.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine took a second item without finishing the first");

   // A non-final item means the token is still in work.
   a_mid_token_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> !req_ready)
      else $error("engine ready while a token's results are incomplete");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.item_kind != KIND_VALUE)) |-> (rsp_data.value_out == 32'd0))
      else $error("value_out nonzero on a non-value item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result item changed while stalled");

endmodule

bind ll1_sexpr_parse_engine_unit ll1sp_checker u_ll1sp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
